// File: rtl/eq_pkg.sv
package eq_pkg;

    // Default build parameters
    localparam int ANGLE_WIDTH = 32;
    localparam int TRIG_STAGES = 24;

    // Internal widths
    localparam int TRIG_W = 34;               // cosine, sine and residual angle, Q30
    localparam int PROD_W = 35;               // rounded first-level product, Q30
    localparam int OPND_W = PROD_W + 1;       // sum or difference of two products
    localparam int MUL_W  = TRIG_W + OPND_W;  // second-level product, Q60
    localparam int SUM_W  = MUL_W + 1;        // two-term sum, Q60
    localparam int COMP_W = SUM_W - 30;       // rounded component, Q30
    localparam int Q_W    = 32;               // output component width

    // Arithmetic constants
    localparam logic signed [63:0] PI_Q60      = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] HALF_PI_Q60 = 64'sh1921FB54442D1846;
    localparam logic signed [63:0] RND_Q60     = 64'sh0000000020000000;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sh026DD3B6A;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_ALT_X = 2'd3;

    // Order code, packed in the same bit order as the input field
    typedef struct packed {
        logic [1:0] axis;
        logic       odd;
        logic       rep;
        logic       rot;
    } t_order;

    // Rotation unit arctangent table, Q30
    function automatic logic signed [TRIG_W-1:0] atan_q30(input int idx);
        logic signed [TRIG_W-1:0] v;
        case (idx)
            0:  v = 34'sh03243F6A8;
            1:  v = 34'sh01DAC6705;
            2:  v = 34'sh00FADBAFC;
            3:  v = 34'sh007F56EA6;
            4:  v = 34'sh003FEAB76;
            5:  v = 34'sh001FFD55B;
            6:  v = 34'sh000FFFAAA;
            7:  v = 34'sh0007FFF55;
            8:  v = 34'sh0003FFFEA;
            9:  v = 34'sh0001FFFFD;
            10: v = 34'sh0000FFFFF;
            11: v = 34'sh00007FFFF;
            12: v = 34'sh00003FFFF;
            13: v = 34'sh00001FFFF;
            14: v = 34'sh00000FFFF;
            15: v = 34'sh000007FFF;
            16: v = 34'sh000003FFF;
            17: v = 34'sh000001FFF;
            18: v = 34'sh000000FFF;
            19: v = 34'sh0000007FF;
            20: v = 34'sh0000003FF;
            21: v = 34'sh0000001FF;
            22: v = 34'sh0000000FF;
            23: v = 34'sh00000007F;
            24: v = 34'sh00000003F;
            25: v = 34'sh00000001F;
            26: v = 34'sh00000000F;
            27: v = 34'sh000000008;
            28: v = 34'sh000000004;
            29: v = 34'sh000000002;
            30: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Next-axis table
    function automatic logic [1:0] next_axis(input logic [1:0] idx);
        logic [1:0] v;
        case (idx)
            2'd0:    v = AXIS_Y;
            2'd1:    v = AXIS_Z;
            2'd2:    v = AXIS_X;
            default: v = AXIS_Y;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/eq_in_if.sv
interface eq_in_if #(
    parameter int ANGLE_WIDTH = eq_pkg::ANGLE_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] angle_first;
    logic signed [ANGLE_WIDTH-1:0] angle_second;
    logic signed [ANGLE_WIDTH-1:0] angle_third;
    logic [4:0]                    order_code;

    modport source (
        output valid, angle_first, angle_second, angle_third, order_code,
        input  ready
    );
    modport sink (
        input  valid, angle_first, angle_second, angle_third, order_code,
        output ready
    );
endinterface

// File: rtl/eq_out_if.sv
interface eq_out_if ();
    logic                           valid;
    logic                           ready;
    logic signed [eq_pkg::Q_W-1:0]  quat_x;
    logic signed [eq_pkg::Q_W-1:0]  quat_y;
    logic signed [eq_pkg::Q_W-1:0]  quat_z;
    logic signed [eq_pkg::Q_W-1:0]  quat_w;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w,
        output ready
    );
endinterface

// File: rtl/eq_trig.sv
module eq_trig #(
    parameter int ANGLE_WIDTH = eq_pkg::ANGLE_WIDTH,
    parameter int TRIG_STAGES = eq_pkg::TRIG_STAGES
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [ANGLE_WIDTH:0]      i_angle,
    output logic signed [eq_pkg::TRIG_W-1:0] o_cos,
    output logic signed [eq_pkg::TRIG_W-1:0] o_sin
);
    localparam int SHIFT = 63 - ANGLE_WIDTH;

    logic signed [63:0] w_t;
    logic signed [63:0] n_t;
    logic               n_flip;
    logic signed [63:0] r_t;
    logic               r_flip_f;
    logic signed [63:0] w_rnd;

    logic signed [eq_pkg::TRIG_W-1:0] r_x [0:TRIG_STAGES];
    logic signed [eq_pkg::TRIG_W-1:0] r_y [0:TRIG_STAGES];
    logic signed [eq_pkg::TRIG_W-1:0] r_z [0:TRIG_STAGES-1];
    logic                             r_flip [0:TRIG_STAGES];

    // Half angle in Q60, folded into the range of the rotation unit
    assign w_t = 64'(i_angle) <<< SHIFT;

    always_comb begin
        n_t    = w_t;
        n_flip = 1'b0;
        if (w_t > eq_pkg::HALF_PI_Q60) begin
            n_t    = w_t - eq_pkg::PI_Q60;
            n_flip = 1'b1;
        end else if (w_t < -eq_pkg::HALF_PI_Q60) begin
            n_t    = w_t + eq_pkg::PI_Q60;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t      <= n_t;
            r_flip_f <= n_flip;
        end
    end

    // Round to Q30 and load the start vector
    assign w_rnd = r_t + eq_pkg::RND_Q60;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]    <= w_rnd[63:30];
            r_x[0]    <= eq_pkg::GAIN_Q30;
            r_y[0]    <= '0;
            r_flip[0] <= r_flip_f;
        end
    end

    // One rotation step per stage
    for (genvar s = 0; s < TRIG_STAGES; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[s+1] <= r_flip[s];
                if (r_z[s] >= 0) begin
                    r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                end else begin
                    r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                end
            end
        end

        // Residual angle feeds the next stage only
        if (s < TRIG_STAGES - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_z[s] >= 0) begin
                        r_z[s+1] <= r_z[s] - eq_pkg::atan_q30(s);
                    end else begin
                        r_z[s+1] <= r_z[s] + eq_pkg::atan_q30(s);
                    end
                end
            end
        end
    end

    // Undo the fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_flip[TRIG_STAGES] ? -r_x[TRIG_STAGES] : r_x[TRIG_STAGES];
            o_sin <= r_flip[TRIG_STAGES] ? -r_y[TRIG_STAGES] : r_y[TRIG_STAGES];
        end
    end

endmodule

// File: rtl/eq_mult.sv
module eq_mult (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  eq_pkg::t_order                   i_ord,
    input  logic signed [eq_pkg::TRIG_W-1:0] i_c1,
    input  logic signed [eq_pkg::TRIG_W-1:0] i_s1,
    input  logic signed [eq_pkg::TRIG_W-1:0] i_c2,
    input  logic signed [eq_pkg::TRIG_W-1:0] i_s2,
    input  logic signed [eq_pkg::TRIG_W-1:0] i_c3,
    input  logic signed [eq_pkg::TRIG_W-1:0] i_s3,
    output logic                             o_vld,
    output logic signed [eq_pkg::Q_W-1:0]    o_quat_x,
    output logic signed [eq_pkg::Q_W-1:0]    o_quat_y,
    output logic signed [eq_pkg::Q_W-1:0]    o_quat_z,
    output logic signed [eq_pkg::Q_W-1:0]    o_quat_w
);
    localparam int TW = eq_pkg::TRIG_W;
    localparam int PW = eq_pkg::PROD_W;
    localparam int OW = eq_pkg::OPND_W;
    localparam int MW = eq_pkg::MUL_W;
    localparam int SW = eq_pkg::SUM_W;
    localparam int CW = eq_pkg::COMP_W;
    localparam int QW = eq_pkg::Q_W;
    localparam logic signed [2*TW-1:0] RND_P = (2*TW)'(64'sd536870912);
    localparam logic signed [SW-1:0]   RND_S = SW'(64'sd536870912);
    localparam logic signed [CW-1:0]   SAT_HI = CW'(64'sd1073741824);
    localparam logic signed [CW-1:0]   SAT_LO = -SAT_HI;

    logic [4:0]      r_vld;
    eq_pkg::t_order  r_ord [0:3];

    // Stage 1: half-angle products of the outer angles
    logic signed [2*TW-1:0] r_cc, r_cs, r_sc, r_ss;
    logic signed [TW-1:0]   r_c2a, r_s2a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc   <= i_c1 * i_c3;
            r_cs   <= i_c1 * i_s3;
            r_sc   <= i_s1 * i_c3;
            r_ss   <= i_s1 * i_s3;
            r_c2a  <= i_c2;
            r_s2a  <= i_s2;
            r_ord[0] <= i_ord;
        end
    end

    // Stage 2: round and pick the operands of each component
    logic signed [2*TW-1:0] w_cc, w_cs, w_sc, w_ss;
    logic signed [PW-1:0]   w_pcc, w_pcs, w_psc, w_pss;
    logic signed [TW-1:0]   n_f1 [0:3];
    logic signed [TW-1:0]   n_f2 [0:3];
    logic signed [OW-1:0]   n_g1 [0:3];
    logic signed [OW-1:0]   n_g2 [0:3];
    logic signed [TW-1:0]   r_f1 [0:3];
    logic signed [TW-1:0]   r_f2 [0:3];
    logic signed [OW-1:0]   r_g1 [0:3];
    logic signed [OW-1:0]   r_g2 [0:3];

    assign w_cc  = r_cc + RND_P;
    assign w_cs  = r_cs + RND_P;
    assign w_sc  = r_sc + RND_P;
    assign w_ss  = r_ss + RND_P;
    assign w_pcc = w_cc[PW+29:30];
    assign w_pcs = w_cs[PW+29:30];
    assign w_psc = w_sc[PW+29:30];
    assign w_pss = w_ss[PW+29:30];

    always_comb begin
        if (r_ord[0].rep) begin
            n_f1[0] = r_c2a; n_g1[0] = OW'(w_pcs) + OW'(w_psc);
            n_f1[1] = r_s2a; n_g1[1] = OW'(w_pcc) + OW'(w_pss);
            n_f1[2] = r_s2a; n_g1[2] = OW'(w_pcs) - OW'(w_psc);
            n_f1[3] = r_c2a; n_g1[3] = OW'(w_pcc) - OW'(w_pss);
            for (int k = 0; k < 4; k++) begin
                n_f2[k] = r_s2a;
                n_g2[k] = '0;
            end
        end else begin
            n_f1[0] = r_c2a; n_g1[0] = OW'(w_psc);
            n_f2[0] = r_s2a; n_g2[0] = -OW'(w_pcs);
            n_f1[1] = r_c2a; n_g1[1] = OW'(w_pss);
            n_f2[1] = r_s2a; n_g2[1] = OW'(w_pcc);
            n_f1[2] = r_c2a; n_g1[2] = OW'(w_pcs);
            n_f2[2] = r_s2a; n_g2[2] = -OW'(w_psc);
            n_f1[3] = r_c2a; n_g1[3] = OW'(w_pcc);
            n_f2[3] = r_s2a; n_g2[3] = OW'(w_pss);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1 <= n_f1;
            r_g1 <= n_g1;
            r_f2 <= n_f2;
            r_g2 <= n_g2;
            r_ord[1] <= r_ord[0];
        end
    end

    // Stage 3: second-level products; stage 4: exact two-term sums
    logic signed [MW-1:0] r_m1 [0:3];
    logic signed [MW-1:0] r_m2 [0:3];
    logic signed [SW-1:0] r_sum [0:3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_m1[k]  <= r_f1[k] * r_g1[k];
                r_m2[k]  <= r_f2[k] * r_g2[k];
                r_sum[k] <= SW'(r_m1[k]) + SW'(r_m2[k]);
            end
            r_ord[2] <= r_ord[1];
            r_ord[3] <= r_ord[2];
        end
    end

    // Stage 5: round, negate the middle component for odd parity, saturate, place on axes
    logic [1:0]           w_ax [0:2];
    logic signed [SW-1:0] w_rs [0:3];
    logic signed [CW-1:0] w_cmp [0:3];
    logic signed [QW-1:0] w_sat [0:3];
    logic signed [QW-1:0] n_axis [0:2];

    always_comb begin
        w_ax[0] = (r_ord[3].axis == eq_pkg::AXIS_ALT_X) ? eq_pkg::AXIS_X : r_ord[3].axis;
        w_ax[1] = eq_pkg::next_axis(w_ax[0] + {1'b0, r_ord[3].odd});
        w_ax[2] = eq_pkg::next_axis(w_ax[0] + 2'd1 - {1'b0, r_ord[3].odd});
        for (int k = 0; k < 4; k++) begin
            w_rs[k]  = r_sum[k] + RND_S;
            w_cmp[k] = w_rs[k][SW-1:30];
            if (k == 1 && r_ord[3].odd) begin
                w_cmp[k] = -w_cmp[k];
            end
            if (w_cmp[k] > SAT_HI) begin
                w_sat[k] = QW'(SAT_HI);
            end else if (w_cmp[k] < SAT_LO) begin
                w_sat[k] = QW'(SAT_LO);
            end else begin
                w_sat[k] = QW'(w_cmp[k]);
            end
        end
        for (int a = 0; a < 3; a++) begin
            n_axis[a] = w_sat[0];
            for (int k = 0; k < 3; k++) begin
                if (w_ax[k] == 2'(a)) begin
                    n_axis[a] = w_sat[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quat_x <= n_axis[eq_pkg::AXIS_X];
            o_quat_y <= n_axis[eq_pkg::AXIS_Y];
            o_quat_z <= n_axis[eq_pkg::AXIS_Z];
            o_quat_w <= w_sat[3];
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    assign o_vld = r_vld[4];

endmodule

// File: rtl/euler_to_quaternion_core.sv
// Throughput: one beat per cycle; the pipeline advances whenever its output
// register is empty or being taken, so the rate is set by the sink alone.
// Depth is set by the rotation unit, one stage per shift-and-add step.
// Reset (i_rst_n low at a clock edge) clears every valid bit; data registers keep no reset.
module euler_to_quaternion_core #(
    parameter int ANGLE_WIDTH = eq_pkg::ANGLE_WIDTH,
    parameter int TRIG_STAGES = eq_pkg::TRIG_STAGES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eq_in_if.sink     i_in,
    eq_out_if.source  o_out
);
    localparam int TRIG_LAT = TRIG_STAGES + 3;
    localparam int TW = eq_pkg::TRIG_W;

    logic w_en;
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // Stage 0: swap for a rotating frame, negate the middle angle for odd parity
    eq_pkg::t_order              w_ord;
    logic signed [ANGLE_WIDTH:0] w_a1, w_a2, w_a3, w_a2n;
    logic signed [ANGLE_WIDTH:0] r_a1, r_a2, r_a3;
    eq_pkg::t_order              r_ord0;
    logic                        r_vld0;

    assign w_ord = i_in.order_code;
    assign w_a1  = w_ord.rot ? (ANGLE_WIDTH+1)'(i_in.angle_third)
                             : (ANGLE_WIDTH+1)'(i_in.angle_first);
    assign w_a3  = w_ord.rot ? (ANGLE_WIDTH+1)'(i_in.angle_first)
                             : (ANGLE_WIDTH+1)'(i_in.angle_third);
    assign w_a2n = (ANGLE_WIDTH+1)'(i_in.angle_second);
    assign w_a2  = w_ord.odd ? -w_a2n : w_a2n;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1   <= w_a1;
            r_a2   <= w_a2;
            r_a3   <= w_a3;
            r_ord0 <= w_ord;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (w_en) begin
            r_vld0 <= i_in.valid;
        end
    end

    // Half-angle sine and cosine, one unit per angle
    logic signed [TW-1:0] w_c1, w_s1, w_c2, w_s2, w_c3, w_s3;

    eq_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_trig1 (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r_a1), .o_cos(w_c1), .o_sin(w_s1)
    );
    eq_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_trig2 (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r_a2), .o_cos(w_c2), .o_sin(w_s2)
    );
    eq_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_trig3 (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r_a3), .o_cos(w_c3), .o_sin(w_s3)
    );

    // Carry valid bit and order code alongside the trig pipeline
    logic           r_vld_line [0:TRIG_LAT-1];
    eq_pkg::t_order r_ord_line [0:TRIG_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TRIG_LAT; i++) begin
                r_vld_line[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld_line[0] <= r_vld0;
            for (int i = 1; i < TRIG_LAT; i++) begin
                r_vld_line[i] <= r_vld_line[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ord_line[0] <= r_ord0;
            for (int i = 1; i < TRIG_LAT; i++) begin
                r_ord_line[i] <= r_ord_line[i-1];
            end
        end
    end

    // Product formulas and output register
    eq_mult u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (r_vld_line[TRIG_LAT-1]),
        .i_ord    (r_ord_line[TRIG_LAT-1]),
        .i_c1     (w_c1),
        .i_s1     (w_s1),
        .i_c2     (w_c2),
        .i_s2     (w_s2),
        .i_c3     (w_c3),
        .i_s3     (w_s3),
        .o_vld    (o_out.valid),
        .o_quat_x (o_out.quat_x),
        .o_quat_y (o_out.quat_y),
        .o_quat_z (o_out.quat_z),
        .o_quat_w (o_out.quat_w)
    );

    // Checks
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    a_xyz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.quat_x <= 32'sd1073741824 && o_out.quat_x >= -32'sd1073741824
            && o_out.quat_y <= 32'sd1073741824 && o_out.quat_y >= -32'sd1073741824
            && o_out.quat_z <= 32'sd1073741824 && o_out.quat_z >= -32'sd1073741824))
        else $error("vector component outside saturation range");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.quat_w <= 32'sd1073741824 && o_out.quat_w >= -32'sd1073741824))
        else $error("scalar component outside saturation range");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output stalled");

endmodule
